### rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  // Storage size and derived widths
  localparam int DEPTH  = 32;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Requested operation
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_LIST       = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What one storage cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

endpackage

### rtl/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
  input  logic                                clk,
  input  deq_pkg::cell_op_t                   cell_op,
  input  logic signed [deq_pkg::WORD_W-1:0]   left_word,
  input  logic signed [deq_pkg::WORD_W-1:0]   right_word,
  input  logic signed [deq_pkg::WORD_W-1:0]   load_word,
  output logic signed [deq_pkg::WORD_W-1:0]   word_r
);

  logic signed [deq_pkg::WORD_W-1:0] word_nxt;

  // Select the word this cell keeps: hold, shift in from a neighbor, or load
  always_comb begin
    unique case (cell_op)
      deq_pkg::CELL_HOLD:       word_nxt = word_r;
      deq_pkg::CELL_FROM_LEFT:  word_nxt = left_word;
      deq_pkg::CELL_FROM_RIGHT: word_nxt = right_word;
      deq_pkg::CELL_LOAD:       word_nxt = load_word;
      default:                  word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of 32 signed 32-bit words, kept in a row of cells
// ordered front to back. A push or pop is accepted when presented and answers with
// one status transaction on the next cycle; busy stays low, so such operations
// can be issued every cycle. A list request over N stored entries holds busy
// high while it streams the N entries one per cycle, front first, with out_last
// on the final one: the cell row rotates by one place per cycle to bring each
// entry to the front cell and is back in its original order when listing ends.
// A list of an empty queue gives a single empty status. Results appear on
// out_valid for exactly one cycle; the receiver cannot stall and must take each
// transaction when it is shown. Operation codes 5 to 7 are dropped without a
// result.
module double_ended_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_operation,
  input  logic signed [deq_pkg::WORD_W-1:0]   in_value,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [deq_pkg::WORD_W-1:0]   out_entry_value,
  output logic                                out_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t                             state_r, state_nxt;
  logic [deq_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [deq_pkg::IDX_W-1:0]          list_idx_r, list_idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  deq_pkg::status_t                   out_status_r, out_status_nxt;
  logic signed [deq_pkg::WORD_W-1:0]  out_entry_r, out_entry_nxt;
  logic                               out_last_r, out_last_nxt;

  deq_pkg::cell_op_t                  cell_op [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0]  cell_word [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0]  cell_left [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0]  cell_right [deq_pkg::DEPTH];
  logic signed [deq_pkg::WORD_W-1:0]  load_word;

  logic                               is_full;
  logic                               is_empty;
  logic                               list_end;

  assign is_full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  assign list_end = ((deq_pkg::CNT_W'(list_idx_r) + deq_pkg::CNT_W'(1)) == count_r);

  // Build the cell row with its neighbor links
  for (genvar g = 0; g < deq_pkg::DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_left[g] = in_value;
    end else begin : g_mid
      assign cell_left[g] = cell_word[g-1];
    end
    if (g == deq_pkg::DEPTH - 1) begin : g_last
      assign cell_right[g] = '0;
    end else begin : g_inner
      assign cell_right[g] = cell_word[g+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .cell_op    (cell_op[g]),
      .left_word  (cell_left[g]),
      .right_word (cell_right[g]),
      .load_word  (load_word),
      .word_r     (cell_word[g])
    );
  end

  // Decode the transaction, steer the cells and form the next result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    list_idx_nxt   = list_idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = deq_pkg::ST_OK;
    out_entry_nxt  = '0;
    out_last_nxt   = 1'b1;
    load_word      = in_value;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      cell_op[i] = deq_pkg::CELL_HOLD;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (deq_pkg::op_t'(in_operation))
            deq_pkg::OP_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = deq_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < deq_pkg::DEPTH; i++) begin
                  cell_op[i] = deq_pkg::CELL_FROM_LEFT;
                end
                count_nxt = count_r + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_status_nxt = deq_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < deq_pkg::DEPTH; i++) begin
                  if (count_r == deq_pkg::CNT_W'(i)) begin
                    cell_op[i] = deq_pkg::CELL_LOAD;
                  end
                end
                count_nxt = count_r + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::OP_LIST: begin
              if (is_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                state_nxt    = S_LIST;
                list_idx_nxt = '0;
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                for (int i = 0; i < deq_pkg::DEPTH; i++) begin
                  cell_op[i] = deq_pkg::CELL_FROM_RIGHT;
                end
                count_nxt = count_r - deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::OP_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - deq_pkg::CNT_W'(1);
              end
            end
            default: begin
              // drop undefined operation codes
            end
          endcase
        end
      end
      S_LIST: begin
        // emit the front cell and rotate it to the back of the stored entries
        out_valid_nxt = 1'b1;
        out_entry_nxt = cell_word[0];
        out_last_nxt  = list_end;
        load_word     = cell_word[0];
        for (int i = 0; i < deq_pkg::DEPTH; i++) begin
          if (count_r == deq_pkg::CNT_W'(i + 1)) begin
            cell_op[i] = deq_pkg::CELL_LOAD;
          end else begin
            cell_op[i] = deq_pkg::CELL_FROM_RIGHT;
          end
        end
        list_idx_nxt = list_idx_r + deq_pkg::IDX_W'(1);
        if (list_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      list_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      list_idx_r  <= list_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r == S_LIST);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_entry_r;
  assign out_last        = out_last_r;

  // Listing only runs over a nonempty queue
  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("list in progress with an empty queue");

  // Entry count stays within the storage
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count beyond storage size");

  // A list stream has no gaps until its last transaction
  a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("list stream broken before last entry");

  // A push into a full queue is refused
  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && is_full &&
     (in_operation == deq_pkg::OP_PUSH_FRONT || in_operation == deq_pkg::OP_PUSH_BACK))
    |=> (out_valid && out_status == deq_pkg::ST_FULL && $stable(count_r)))
    else $error("push into full queue not refused");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  // Operation codes the block drops without a result
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  localparam int RANDOM_ITEMS = 60;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    status_t                   status;
    logic signed [WORD_W-1:0]  entry_value;
    logic                      last;
  } deq_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [2:0]                in_operation = OP_PUSH_FRONT;
  logic signed [WORD_W-1:0]  in_value = '0;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic signed [WORD_W-1:0]  out_entry_value;
  logic                      out_last;

  // Shadow copy of the deque contents
  logic signed [WORD_W-1:0]  held_words [DEPTH];
  int unsigned               held_front = 0;
  int unsigned               held_count = 0;

  deq_result_t               expected_results [$];
  int                        error_count = 0;
  int                        cycle_count = 0;
  int                        idle_free_left = 0;

  double_ended_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_value (out_entry_value),
    .out_last        (out_last)
  );

  always #1 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Update the shadow deque and queue up the transactions this request yields
  task automatic predict_deque(input logic [2:0] op, input logic signed [WORD_W-1:0] word);
    deq_result_t r;
    r.status      = ST_OK;
    r.entry_value = '0;
    r.last        = 1'b1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          held_front = (held_front + DEPTH - 1) % DEPTH;
          held_words[held_front] = word;
          held_count++;
        end else begin
          held_words[(held_front + held_count) % DEPTH] = word;
          held_count++;
        end
        expected_results.push_back(r);
      end
      OP_LIST: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          for (int unsigned k = 0; k < held_count; k++) begin
            r.entry_value = held_words[(held_front + k) % DEPTH];
            r.last        = (k + 1 == held_count);
            expected_results.push_back(r);
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) held_front = (held_front + 1) % DEPTH;
          held_count--;
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones, and occasional stretches with none
  function automatic int pick_gap();
    int r;
    if (idle_free_left > 0) begin
      idle_free_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) idle_free_left = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one request, hold it until the block takes it, then idle for a random gap, which may be zero
  task automatic send_item(input logic [2:0] op, input logic signed [WORD_W-1:0] word);
    int gap;
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= word;
    do @(posedge clk); while (busy !== 1'b0);
    predict_deque(op, word);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d entry_value %0d last %0d",
               out_status, out_entry_value, out_last);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        if (out_entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, actual %0d", want.entry_value, out_entry_value);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Empty list, pops on an empty deque, and the dropped operation codes
  task automatic test_empty_queue();
    send_item(OP_LIST, pick_word());
    send_item(OP_POP_FRONT, pick_word());
    send_item(OP_POP_BACK, pick_word());
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) send_item(c[2:0], pick_word());
  endtask

  // Ordering at both ends with extreme words
  task automatic test_push_pop_order();
    send_item(OP_PUSH_BACK, WORD_MIN);
    send_item(OP_PUSH_FRONT, WORD_MAX);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_PUSH_FRONT, '1);
    send_item(OP_LIST, pick_word());
    send_item(OP_POP_FRONT, pick_word());
    send_item(OP_POP_BACK, pick_word());
    send_item(OP_LIST, pick_word());
    send_item(OP_POP_BACK, pick_word());
    send_item(OP_POP_FRONT, pick_word());
    send_item(OP_POP_FRONT, pick_word());
    send_item(OP_LIST, pick_word());
  endtask

  // Fill to capacity, refuse pushes at both ends, list the full deque
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++) send_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
    send_item(OP_PUSH_FRONT, pick_word());
    send_item(OP_PUSH_BACK, pick_word());
    send_item(OP_LIST, pick_word());
    send_item(OP_POP_FRONT, pick_word());
    send_item(OP_PUSH_BACK, WORD_MAX);
    send_item(OP_PUSH_FRONT, WORD_MIN);
  endtask

  // Random mix that swings the fill level between empty and full
  task automatic test_random_mix(input int n_items);
    int     sent;
    int     r;
    bit     filling;
    logic [2:0] op;
    sent    = 0;
    filling = (held_count < DEPTH / 2);
    while (sent < n_items) begin
      if (filling && held_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (!filling && held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      if ($urandom_range(0, 29) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (r < 13) begin
        op = OP_LIST;
        sent++;
      end else if (r < (filling ? 73 : 33)) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        sent++;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        sent++;
      end
      send_item(op, pick_word());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_push_pop_order();
    test_full_queue();
    test_random_mix(RANDOM_ITEMS);
    start <= 1'b0;

    // Wait for outstanding results, then watch for stragglers
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### double_ended_queue.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
dv/testbench.sv
